// File: rtl/lst_pkg.sv
// Shared types, widths and codes for the lottery scheduler table unit.
// No dependencies; compiled first.
package lst_pkg;

    localparam int LST_MAX_THREADS = 16;

    localparam int MODE_W   = 2;
    localparam int ID_W     = 16;
    localparam int TK_W     = 16;
    localparam int RND_W    = 31;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 20;
    localparam int ALU_W    = TOTAL_W + 1;
    localparam int BIT_W    = $clog2(RND_W);
    localparam int ENTRY_W  = ID_W + TK_W;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DRAW   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_ZERO      = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_MOD,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_SUB,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             borrow;
    } t_alu_rsp;

endpackage

// File: rtl/lst_if.sv
// Valid/ready channel interfaces for request and result transfers.
// Depends on lst_pkg.
interface lst_in_if import lst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   thread_id;
    logic [TK_W-1:0]   ticket_count;
    logic [RND_W-1:0]  random_value;

    modport source(output valid, mode, thread_id, ticket_count, random_value, input ready);
    modport sink(input valid, mode, thread_id, ticket_count, random_value, output ready);
endinterface

interface lst_out_if import lst_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     result_id;

    modport source(output valid, status, result_id, input ready);
    modport sink(input valid, status, result_id, output ready);
endinterface

// File: rtl/lottery_scheduler_table_unit.sv
// Lottery scheduler table: sequencer, entry RAM and shared add/subtract unit.
// Depends on lst_pkg, lst_if, lst_ram and lst_addsub.
//
// Usage: requests arrive on i_in (mode, thread_id, ticket_count, random_value)
// and each produces exactly one result on o_out (status, result_id).
// A request is taken when valid and ready are high at a clock edge; ready is
// high only while the sequencer is idle, so one request is in work at a time.
// Work per request, from transfer to result valid, with n live entries:
//   add            write the new entry, add its tickets to the total
//   remove         search up to n entries for the id, subtract, shift later ones down
//   draw           bit-serial remainder, then walk up to n entries
//   error / other  straight to the result
// A draw runs the bit-serial remainder (31 steps through the shared
// subtractor), then a registered RAM read and a check per entry walked.
// The result sits in an output register; a new request may be taken while it
// waits. If the receiver stalls, the next result waits in the sequencer.
// Reset (i_rst_n low, synchronous) empties the table, zeroes the ticket
// total and the id counter and drops any pending result. The entry RAM is
// not cleared; only entries below the entry count are ever read.
module lottery_scheduler_table_unit import lst_pkg::*; #(
    parameter int MAX_THREADS = LST_MAX_THREADS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lst_in_if.sink    i_in,
    lst_out_if.source o_out
);

    localparam int IW = $clog2(MAX_THREADS);
    localparam int CW = $clog2(MAX_THREADS + 1);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [ID_W-1:0]     r_next_id, n_next_id;
    logic [ID_W-1:0]     r_tid, n_tid;
    logic [TK_W-1:0]     r_tickets, n_tickets;
    logic [RND_W-1:0]    r_rnd, n_rnd;
    logic [TOTAL_W-1:0]  r_rem, n_rem;
    logic [BIT_W-1:0]    r_bit, n_bit;
    logic [IW-1:0]       r_idx, n_idx;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [ID_W-1:0]     r_res_id, n_res_id;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [ID_W-1:0]     r_out_id, n_out_id;

    logic               w_accept;
    logic               w_out_free;
    logic [CW-1:0]      w_idx_inc;
    logic               w_idx_last;
    logic [ALU_W-1:0]   w_rem_sh;
    t_alu_req           w_req;
    t_alu_rsp           w_rsp;
    logic               w_we;
    logic [IW-1:0]      w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic [IW-1:0]      w_raddr;
    logic [ENTRY_W-1:0] w_rdata;
    logic [ID_W-1:0]    w_rd_id;
    logic [TK_W-1:0]    w_rd_tk;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_idx_inc  = CW'(r_idx) + CW'(1);
    assign w_idx_last = (w_idx_inc == r_count);
    assign w_rem_sh   = {r_rem, r_rnd[r_bit]};
    assign w_rd_id    = w_rdata[ENTRY_W-1:TK_W];
    assign w_rd_tk    = w_rdata[TK_W-1:0];

    lst_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_THREADS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    lst_addsub u_alu (
        .i_req(w_req),
        .o_rsp(w_rsp)
    );

    always_comb begin
        unique case (r_state)
            ST_MOD:      w_req = '{sub: 1'b1, a: w_rem_sh, b: ALU_W'(r_total)};
            ST_WALK_CHK: w_req = '{sub: 1'b1, a: ALU_W'(r_rem), b: ALU_W'(w_rd_tk)};
            ST_SUB:      w_req = '{sub: 1'b1, a: ALU_W'(r_total), b: ALU_W'(r_tickets)};
            default:     w_req = '{sub: 1'b0, a: ALU_W'(r_total), b: ALU_W'(r_tickets)};
        endcase
    end

    always_comb begin
        w_we    = (r_state == ST_ADD) || (r_state == ST_SHIFT_WR);
        w_waddr = (r_state == ST_ADD) ? r_count[IW-1:0] : r_idx;
        w_wdata = (r_state == ST_ADD) ? {r_next_id, r_tickets} : w_rdata;
        w_raddr = (r_state == ST_SHIFT_RD) ? w_idx_inc[IW-1:0] : r_idx;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    priority case (i_in.mode)
                        MODE_ADD:
                            n_state = (r_count == CW'(MAX_THREADS)) ? ST_DONE : ST_ADD;
                        MODE_REMOVE:
                            n_state = (r_count == '0) ? ST_DONE : ST_FIND_RD;
                        MODE_DRAW:
                            n_state = (r_count == '0 || r_total == '0) ? ST_DONE : ST_MOD;
                        default:
                            n_state = ST_DONE;
                    endcase
                end
            end
            ST_ADD:      n_state = ST_DONE;
            ST_MOD:      n_state = (r_bit == '0) ? ST_WALK_RD : ST_MOD;
            ST_WALK_RD:  n_state = ST_WALK_CHK;
            ST_WALK_CHK: n_state = (w_rsp.borrow || w_idx_last) ? ST_DONE : ST_WALK_RD;
            ST_FIND_RD:  n_state = ST_FIND_CHK;
            ST_FIND_CHK: begin
                if (w_rd_id == r_tid) begin
                    n_state = ST_SUB;
                end else if (w_idx_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_FIND_RD;
                end
            end
            ST_SUB:      n_state = (w_idx_inc < r_count) ? ST_SHIFT_RD : ST_DONE;
            ST_SHIFT_RD: n_state = ST_SHIFT_WR;
            ST_SHIFT_WR: n_state = (w_idx_inc < r_count) ? ST_SHIFT_RD : ST_DONE;
            ST_DONE:     n_state = w_out_free ? ST_IDLE : ST_DONE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count      = r_count;
        n_total      = r_total;
        n_next_id    = r_next_id;
        n_tid        = r_tid;
        n_tickets    = r_tickets;
        n_rnd        = r_rnd;
        n_rem        = r_rem;
        n_bit        = r_bit;
        n_idx        = r_idx;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_tid        = i_in.thread_id;
                    n_tickets    = i_in.ticket_count;
                    n_rnd        = i_in.random_value;
                    n_rem        = '0;
                    n_bit        = BIT_W'(RND_W - 1);
                    n_idx        = '0;
                    n_res_status = STAT_OK;
                    n_res_id     = '0;
                    priority case (i_in.mode)
                        MODE_ADD: begin
                            if (r_count == CW'(MAX_THREADS)) begin
                                n_res_status = STAT_FULL;
                            end
                        end
                        MODE_REMOVE: begin
                            if (r_count == '0) begin
                                n_res_status = STAT_EMPTY;
                            end
                        end
                        MODE_DRAW: begin
                            if (r_count == '0) begin
                                n_res_status = STAT_EMPTY;
                            end else if (r_total == '0) begin
                                n_res_status = STAT_ZERO;
                            end
                        end
                        default: n_res_status = STAT_OK;
                    endcase
                end
            end
            ST_ADD: begin
                n_total   = w_rsp.res[TOTAL_W-1:0];
                n_count   = r_count + CW'(1);
                n_next_id = r_next_id + ID_W'(1);
                n_res_id  = r_next_id;
            end
            ST_MOD: begin
                n_rem = w_rsp.borrow ? w_rem_sh[TOTAL_W-1:0] : w_rsp.res[TOTAL_W-1:0];
                n_bit = r_bit - BIT_W'(1);
            end
            ST_WALK_CHK: begin
                n_rem    = w_rsp.res[TOTAL_W-1:0];
                n_idx    = w_idx_inc[IW-1:0];
                n_res_id = w_rd_id;
            end
            ST_FIND_CHK: begin
                if (w_rd_id == r_tid) begin
                    n_tickets = w_rd_tk;
                end else if (w_idx_last) begin
                    n_res_status = STAT_NOT_FOUND;
                end else begin
                    n_idx = w_idx_inc[IW-1:0];
                end
            end
            ST_SUB: begin
                n_total  = w_rsp.res[TOTAL_W-1:0];
                n_count  = r_count - CW'(1);
                n_res_id = r_tid;
            end
            ST_SHIFT_WR: n_idx = w_idx_inc[IW-1:0];
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_id     = r_res_id;
                end
            end
            default: n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_next_id   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_next_id   <= n_next_id;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tid        <= n_tid;
        r_tickets    <= n_tickets;
        r_rnd        <= n_rnd;
        r_rem        <= n_rem;
        r_bit        <= n_bit;
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
    end

    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_status;
    assign o_out.result_id = r_out_id;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_THREADS))
        else $error("entry count beyond table depth");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in.ready)
        else $error("ready stayed high after request transfer");

    a_rem_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK_CHK) |-> (r_rem < r_total))
        else $error("reduced draw not below ticket total");

    a_add_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("add did not grow the table");

    a_done_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && w_out_free) |=> o_out.valid)
        else $error("finished result not presented");

endmodule

// File: rtl/lst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lst_addsub.sv
// Shared add/subtract unit with borrow out, used for the ticket total, remainder and draw-walk steps.
// Depends on lst_pkg.
module lst_addsub import lst_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [ALU_W:0] w_sum;

    always_comb begin
        if (i_req.sub) begin
            w_sum = {1'b0, i_req.a} - {1'b0, i_req.b};
        end else begin
            w_sum = {1'b0, i_req.a} + {1'b0, i_req.b};
        end
    end

    assign o_rsp.res    = w_sum[ALU_W-1:0];
    assign o_rsp.borrow = w_sum[ALU_W];

endmodule
